// ===== rtl/pfd_pkg.sv =====
// shared types, constants and the crc-8 step function for the presence frame deframer
// no dependencies
`default_nettype none

package pfd_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 64;

	localparam logic [7:0]  SOF_BYTE          = 8'h53;
	localparam logic [7:0]  EOF_BYTE          = 8'h54;
	localparam logic [7:0]  CRC_POLY          = 8'h31;
	localparam logic [15:0] STALE_LIMIT_RESET = 16'd500;

	// shortest frame: start, length low/high, type, crc, end
	localparam int MIN_FRAME_BYTES = 6;
	// frame bytes around the payload counted by the length field
	localparam logic [16:0] LEN_OVERHEAD = 17'd5;

	// frame byte positions
	localparam int POS_LEN_LO  = 1;
	localparam int POS_LEN_HI  = 2;
	localparam int POS_TYPE    = 3;
	localparam int POS_PAYLOAD = 5;

	typedef enum logic {
		CMD_BYTE    = 1'b0,
		CMD_TIMEOUT = 1'b1
	} pfd_cmd_t;

	typedef enum logic [1:0] {
		PRES_UNKNOWN = 2'd0,
		PRES_NOONE   = 2'd1,
		PRES_MOTION  = 2'd2,
		PRES_STATIC  = 2'd3
	} pfd_pres_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} pfd_byte_t;

	typedef struct packed {
		logic        frame_accepted;
		logic        frame_dropped;
		logic [1:0]  presence_state;
		logic [7:0]  energy_level;
		logic        reading_valid;
		logic [31:0] reading_time_ms;
		logic [31:0] drop_total;
		logic        presence_detected;
		logic        reading_stale;
	} pfd_status_t;

	// one byte through the msb-first crc-8 register
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pfd_if.sv =====
// valid/ready channel interfaces for the presence frame deframer
// depends on pfd_pkg
`default_nettype none

interface pfd_byte_if;
	import pfd_pkg::*;
	logic      valid;
	logic      ready;
	pfd_byte_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pfd_status_if;
	import pfd_pkg::*;
	logic        valid;
	logic        ready;
	pfd_status_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/presence_frame_deframer_crc8_core.sv =====
// presence sensor frame deframer: start/end hunt, length and crc-8 check, reading store
// depends on pfd_pkg and the channel interfaces in pfd_if.sv
// an accepted item moves from the input register s1 into the result register s2
// throughput: one item per cycle while status_ch is ready, set by the frame/crc update on the s1 register
// a result held by a not-ready status_ch stalls s2, and s1 as well once it holds an item
// reset: asynchronous, active low; hunt state, stored reading and drop count clear,
// stale limit returns to 500 ms, both channels show no valid item
`default_nettype none

module presence_frame_deframer_crc8_core #(
	parameter int MAX_FRAME_BYTES = pfd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pfd_byte_if.sink         byte_ch,
	pfd_status_if.source     status_ch,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import pfd_pkg::*;

	// wide enough to hold the full store count itself
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

	// pipeline control
	logic        v_s1;
	pfd_byte_t   byte_s1;
	logic        v_s2;
	pfd_status_t status_s2;
	logic        adv;

	// configuration
	logic [15:0] stale_limit_q;

	// frame assembly state
	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic [7:0]       crc_q;
	logic [7:0]       d0_q, d1_q;
	logic [15:0]      len_q;
	logic [7:0]       type_q;
	logic [7:0]       fpb_q;

	// stored reading
	logic [1:0]  st_state_q;
	logic [7:0]  st_energy_q;
	logic        st_valid_q;
	logic [31:0] st_time_q;
	logic [31:0] drops_q;

	// next values
	logic             in_frame_n;
	logic [POS_W-1:0] pos_n;
	logic             ovf_n;
	logic [7:0]       crc_n;
	logic [7:0]       d0_n, d1_n;
	logic [15:0]      len_n;
	logic [7:0]       type_n;
	logic [7:0]       fpb_n;
	logic [1:0]       st_state_n;
	logic [7:0]       st_energy_n;
	logic             st_valid_n;
	logic [31:0]      st_time_n;
	logic [31:0]      drops_n;

	logic             accepted, dropped, frame_ok;
	logic [31:0]      age_q, age_n;
	logic [16:0]      len_need;
	pfd_status_t      status_n;

	// the whole pipe moves when the result register is free or being emptied
	assign adv           = !v_s2 || status_ch.ready;
	assign byte_ch.ready = !v_s1 || adv;

	assign status_ch.valid = v_s2;
	assign status_ch.data  = status_s2;

	// age of the stored reading before this item's update
	assign age_q = byte_s1.now_ms - st_time_q;

	always_comb begin
		in_frame_n  = in_frame_q;
		pos_n       = pos_q;
		ovf_n       = ovf_q;
		crc_n       = crc_q;
		d0_n        = d0_q;
		d1_n        = d1_q;
		len_n       = len_q;
		type_n      = type_q;
		fpb_n       = fpb_q;
		st_state_n  = st_state_q;
		st_energy_n = st_energy_q;
		st_valid_n  = st_valid_q;
		st_time_n   = st_time_q;
		drops_n     = drops_q;
		accepted    = 1'b0;
		dropped     = 1'b0;
		frame_ok    = 1'b0;
		len_need    = '0;

		if (byte_s1.command == CMD_TIMEOUT) begin
			// timeout: stale reading counts as a drop, partial frame is thrown away
			if (st_time_q != '0 && age_q > {16'd0, stale_limit_q}) begin
				drops_n = drops_q + 32'd1;
				dropped = 1'b1;
			end
			in_frame_n = 1'b0;
		end else if (!in_frame_q) begin
			// hunting for the start byte
			if (byte_s1.rx_byte == SOF_BYTE) begin
				in_frame_n = 1'b1;
				pos_n      = POS_W'(1);
				ovf_n      = 1'b0;
				crc_n      = '0;
				d0_n       = '0;
				d1_n       = '0;
				len_n      = '0;
				type_n     = '0;
				fpb_n      = '0;
			end
		end else begin
			if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
				// crc lags two bytes behind so the crc byte itself stays out
				if (pos_q >= POS_W'(POS_PAYLOAD))
					crc_n = crc8_fold(crc_q, d1_q);
				if (pos_q == POS_W'(POS_LEN_LO))
					len_n = {len_q[15:8], byte_s1.rx_byte};
				if (pos_q == POS_W'(POS_LEN_HI))
					len_n = {byte_s1.rx_byte, len_q[7:0]};
				if (pos_q == POS_W'(POS_TYPE))
					type_n = byte_s1.rx_byte;
				if (pos_q == POS_W'(POS_PAYLOAD))
					fpb_n = byte_s1.rx_byte;
				d1_n  = d0_q;
				d0_n  = byte_s1.rx_byte;
				pos_n = pos_q + POS_W'(1);
			end else begin
				ovf_n = 1'b1;
			end

			if (byte_s1.rx_byte == EOF_BYTE) begin
				len_need = {1'b0, len_n} + LEN_OVERHEAD;
				frame_ok = !ovf_n && (pos_n >= POS_W'(MIN_FRAME_BYTES)) &&
					(len_need <= 17'(pos_n)) && (crc_n == d1_n);
				if (frame_ok) begin
					st_time_n   = byte_s1.now_ms;
					st_valid_n  = 1'b1;
					st_energy_n = (len_n != '0) ? fpb_n : 8'd0;
					if (type_n inside {8'd1, 8'd2, 8'd3})
						st_state_n = type_n[1:0];
					else
						st_state_n = PRES_UNKNOWN;
					drops_n  = '0;
					accepted = 1'b1;
				end else begin
					drops_n = drops_q + 32'd1;
					dropped = 1'b1;
				end
				in_frame_n = 1'b0;
			end
		end

		// a fresh reading has age zero, otherwise the stored time is unchanged
		age_n = accepted ? 32'd0 : age_q;

		status_n.frame_accepted    = accepted;
		status_n.frame_dropped     = dropped;
		status_n.presence_state    = st_state_n;
		status_n.energy_level      = st_energy_n;
		status_n.reading_valid     = st_valid_n;
		status_n.reading_time_ms   = st_time_n;
		status_n.drop_total        = drops_n;
		status_n.presence_detected = st_valid_n && (age_n <= {16'd0, stale_limit_q}) &&
			(st_state_n == PRES_MOTION || st_state_n == PRES_STATIC);
		status_n.reading_stale     = !st_valid_n || (st_time_n == '0) ||
			(age_n > {16'd0, stale_limit_q});
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			v_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			status_s2 <= status_n;
		end
	end

	// stale limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= STALE_LIMIT_RESET;
		end else if (cfg_we) begin
			stale_limit_q <= cfg_wdata;
		end
	end

	// frame and reading state, updated as each item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			crc_q       <= '0;
			d0_q        <= '0;
			d1_q        <= '0;
			len_q       <= '0;
			type_q      <= '0;
			fpb_q       <= '0;
			st_state_q  <= PRES_UNKNOWN;
			st_energy_q <= '0;
			st_valid_q  <= 1'b0;
			st_time_q   <= '0;
			drops_q     <= '0;
		end else if (adv && v_s1) begin
			in_frame_q  <= in_frame_n;
			pos_q       <= pos_n;
			ovf_q       <= ovf_n;
			crc_q       <= crc_n;
			d0_q        <= d0_n;
			d1_q        <= d1_n;
			len_q       <= len_n;
			type_q      <= type_n;
			fpb_q       <= fpb_n;
			st_state_q  <= st_state_n;
			st_energy_q <= st_energy_n;
			st_valid_q  <= st_valid_n;
			st_time_q   <= st_time_n;
			drops_q     <= drops_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pfd_checker.sv =====
// port-level checks for the presence frame deframer, bound to the deframer core
// depends on pfd_pkg
`default_nettype none

module pfd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              st_valid,
	input wire logic              st_ready,
	input wire pfd_pkg::pfd_status_t st_data
);
	import pfd_pkg::*;

	// a result never both accepts and drops
	a_acc_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid |-> !(st_data.frame_accepted && st_data.frame_dropped))
		else $error("result both accepted and dropped a frame");

	// an accepted frame leaves a valid reading and a cleared drop count
	a_acc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_valid && st_data.frame_accepted) |->
		(st_data.reading_valid && st_data.drop_total == 32'd0))
		else $error("accepted frame without valid reading or zero drop count");

	// presence needs a valid reading in motion or static state
	a_presence: assert property (@(posedge clk) disable iff (!arst_n)
		(st_valid && st_data.presence_detected) |->
		(st_data.reading_valid &&
		(st_data.presence_state == PRES_MOTION || st_data.presence_state == PRES_STATIC)))
		else $error("presence reported without a valid active reading");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_valid && !st_ready) |=> (st_valid && $stable(st_data)))
		else $error("stalled result changed or vanished");

endmodule

bind presence_frame_deframer_crc8_core pfd_checker u_pfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.st_valid (status_ch.valid),
	.st_ready (status_ch.ready),
	.st_data  (status_ch.data)
);

`default_nettype wire
